// ===== src/mcut_pkg.sv =====
// ----------------------------------------------------------------------------
// mcut_pkg: shared types and constants
// Widths, mode codes, register indexes and the word/lane status types used by
// the multi-channel UART transfer unit.
// ----------------------------------------------------------------------------
package mcut_pkg;

    localparam int MAX_LINES    = 4;
    localparam int BYTE_W       = 8;
    localparam int DATA_BITS    = 8;
    localparam int FRAME_BITS   = 10;
    localparam int PERIOD_W     = 16;
    localparam int TIMEOUT_W    = 16;
    localparam int DELAY_W      = 20;
    localparam int ACTIVE_W     = 3;
    localparam int TICKS_PER_MS = 1000;
    // elapsed time never passes 65535 ms worth of ticks
    localparam int ELAPSED_W    = 26;
    localparam int LIMIT_W      = 26;
    // due times lead elapsed time by 1.5 bit periods or the start delay at most
    localparam int TIME_W       = 27;
    localparam int CNT_W        = 3;
    localparam int FCNT_W       = 4;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [1:0] MODE_DISC = 2'd0;
    localparam logic [1:0] MODE_IDLE = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;
    localparam logic [1:0] MODE_DONE = 2'd3;

    localparam logic REQ_START = 1'b0;

    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_TX_DELAY   = 2'd2;
    localparam logic [1:0] REG_ACTIVE_RX  = 2'd3;

    localparam logic [PERIOD_W-1:0]  RST_BIT_PERIOD = 16'd104;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 16'd100;
    localparam logic [LIMIT_W-1:0]   RST_LIMIT      = 26'd100000;

    typedef struct packed {
        logic              done;
        logic              conn;
        logic [BYTE_W-1:0] shift;
    } lane_stat_t;

    typedef struct packed {
        logic                        tx_line;
        logic                        busy;
        logic                        finished;
        logic                        timed_out;
        logic [MAX_LINES-1:0]        done_mask;
        logic [MAX_LINES-1:0]        conn_mask;
        logic [MAX_LINES*BYTE_W-1:0] bytes;
    } result_t;

endpackage

// ===== src/mcut_rx_lane.sv =====
// ----------------------------------------------------------------------------
// mcut_rx_lane: one 8-bit UART receiver lane
// Waits for a falling line, samples at mid-bit once per bit period, LSB first.
// ----------------------------------------------------------------------------
module mcut_rx_lane
    import mcut_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  logic                 enable,
    input  logic                 line,
    input  logic [ELAPSED_W-1:0] now,
    input  logic [PERIOD_W-1:0]  period,
    output logic                 pending,
    output lane_stat_t           stat_next
);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_BITS - 1);

    logic [1:0]        mode_reg, mode_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] due_reg, due_next;
    logic [TIME_W-1:0] now_ext;

    assign now_ext = TIME_W'(now);

    always_comb
    begin
        mode_next  = mode_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        due_next   = due_reg;
        if (start)
        begin
            mode_next  = (enable && line) ? MODE_IDLE : MODE_DISC;
            shift_next = '0;
            cnt_next   = '0;
            due_next   = '0;
        end
        else if (step)
        begin
            if (mode_reg == MODE_IDLE && !line)
            begin
                // first sample lands in the middle of data bit 0
                mode_next = MODE_RUN;
                due_next  = now_ext + TIME_W'(period) + TIME_W'(period >> 1);
            end
            else if (mode_reg == MODE_RUN && due_reg <= now_ext)
            begin
                shift_next = shift_reg | (BYTE_W'(line) << cnt_reg);
                cnt_next   = cnt_reg + 1'b1;
                due_next   = due_reg + TIME_W'(period);
                if (cnt_reg == LAST_BIT)
                begin
                    mode_next = MODE_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_DISC;
            shift_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg <= due_next;
    end

    assign pending         = (mode_reg == MODE_IDLE) || (mode_reg == MODE_RUN);
    assign stat_next.done  = (mode_next == MODE_DONE);
    assign stat_next.conn  = (mode_next != MODE_DISC);
    assign stat_next.shift = shift_next;

endmodule

// ===== src/mcut_tx.sv =====
// ----------------------------------------------------------------------------
// mcut_tx: 8N1 transmitter
// Shifts out start, 8 data and stop bits, one per bit period after the delay.
// ----------------------------------------------------------------------------
module mcut_tx
    import mcut_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  logic [BYTE_W-1:0]    send_byte,
    input  logic [DELAY_W-1:0]   delay,
    input  logic [PERIOD_W-1:0]  period,
    input  logic [ELAPSED_W-1:0] now,
    output logic                 active,
    output logic                 level_next
);

    localparam logic [FCNT_W-1:0] FRAME_LEN = FCNT_W'(FRAME_BITS);

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [FCNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_W-1:0]     due_reg, due_next;
    logic                  level_reg;

    assign active = (cnt_reg < FRAME_LEN);

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        due_next   = due_reg;
        level_next = level_reg;
        if (start)
        begin
            frame_next = {1'b1, send_byte, 1'b0};
            cnt_next   = '0;
            due_next   = TIME_W'(delay);
            level_next = 1'b1;
        end
        else if (step && active && due_reg <= TIME_W'(now))
        begin
            level_next = frame_reg[0];
            frame_next = {1'b1, frame_reg[FRAME_BITS-1:1]};
            cnt_next   = cnt_reg + 1'b1;
            due_next   = due_reg + TIME_W'(period);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '1;
            cnt_reg   <= FRAME_LEN;
            due_reg   <= '0;
            level_reg <= 1'b1;
        end
        else
        begin
            frame_reg <= frame_next;
            cnt_reg   <= cnt_next;
            due_reg   <= due_next;
            level_reg <= level_next;
        end
    end

endmodule

// ===== src/mcut_merge.sv =====
// ----------------------------------------------------------------------------
// mcut_merge: lane merge
// Gathers lane status into the packed masks and bytes of the result word.
// ----------------------------------------------------------------------------
module mcut_merge
    import mcut_pkg::*;
#(
    parameter int NUM_LANES = 4
)
(
    input  lane_stat_t           stat [NUM_LANES],
    input  logic [NUM_LANES-1:0] pend,
    input  logic                 tx_level,
    input  logic                 busy,
    input  logic                 fin,
    input  logic                 tmo,
    output logic                 any_pending,
    output result_t              result
);

    assign any_pending = |pend;

    assign result.tx_line   = tx_level;
    assign result.busy      = busy;
    assign result.finished  = fin;
    assign result.timed_out = tmo;

    for (genvar i = 0; i < MAX_LINES; i++)
    begin : g_pack
        if (i < NUM_LANES)
        begin : g_lane
            assign result.done_mask[i]             = stat[i].done;
            assign result.conn_mask[i]             = stat[i].conn;
            assign result.bytes[i*BYTE_W +: BYTE_W] = stat[i].shift;
        end
        else
        begin : g_none
            assign result.done_mask[i]             = 1'b0;
            assign result.conn_mask[i]             = 1'b0;
            assign result.bytes[i*BYTE_W +: BYTE_W] = '0;
        end
    end

endmodule

// ===== src/mcut_out_buf.sv =====
// ----------------------------------------------------------------------------
// mcut_out_buf: output register with skid stage
// Holds result words for the receiver; stalls the input only when both are full.
// ----------------------------------------------------------------------------
module mcut_out_buf
    import mcut_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  result_t wdata,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t rdata,
    output logic    full
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // input is stalled while the skid word is held
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (wr)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = wdata;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = wdata;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign rdata     = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

// ===== src/multi_channel_uart_transfer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_uart_transfer_unit: one-shot UART exchange
// One 8N1 transmitter and up to four 8-bit receivers, timed by tick words.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_stall) are either a start word, which loads
//   send_byte, arms each enabled receiver whose line is high and clears the
//   elapsed time, or a one-microsecond tick word carrying the line levels.
//   Each input word yields exactly one result word (out_valid/out_stall)
//   with the transmit level, busy/finished/timed_out flags, receiver masks
//   and the bytes sampled so far.
//   Results are registered; one word per clock is sustained while out_stall
//   is low. All receiver lanes update in the same cycle and the merge is
//   combinational, so the tick rate is set by the lane compare/add path. When
//   the receiver stalls, one more word is absorbed by a skid register, then
//   in_stall rises until the output word is taken. Registers are to be
//   written over the APB port between words; the block does not enforce it.
//   Bit period and timeout act at once, receiver count and start delay at the
//   next start. Reset clears the exchange, idles the transmit line high and
//   loads the default register values (104 us bit, 100 ms timeout).
// ----------------------------------------------------------------------------
module multi_channel_uart_transfer_unit
    import mcut_pkg::*;
#(
    parameter int NUM_RECEIVERS = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [BYTE_W-1:0]           send_byte,
    input  logic [MAX_LINES-1:0]        rx_lines,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        tx_line,
    output logic                        busy_res,
    output logic                        finished,
    output logic                        timed_out,
    output logic [MAX_LINES-1:0]        rx_done_mask,
    output logic [MAX_LINES-1:0]        rx_connected_mask,
    output logic [MAX_LINES*BYTE_W-1:0] rx_bytes
);

    // lanes are capped at MAX_LINES; lines without a lane stay disconnected
    localparam int NUM_LANES = (NUM_RECEIVERS < MAX_LINES) ? NUM_RECEIVERS : MAX_LINES;

    logic [PERIOD_W-1:0]  bit_period_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic [ACTIVE_W-1:0]  active_reg;

    logic                 busy_reg, busy_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next, tick_now;

    logic                 cfg_wr;
    logic                 accept, is_start, start, step, end_now, tmo;
    logic                 any_pending, tx_active, tx_level_next;
    logic [NUM_LANES-1:0] lane_pend;
    lane_stat_t           lane_stat [NUM_LANES];
    result_t              result, out_word;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= RST_BIT_PERIOD;
            timeout_reg    <= RST_TIMEOUT;
            limit_reg      <= RST_LIMIT;
            delay_reg      <= '0;
            active_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BIT_PERIOD: bit_period_reg <= pwdata[PERIOD_W-1:0];
                REG_TIMEOUT:
                begin
                    timeout_reg <= pwdata[TIMEOUT_W-1:0];
                    limit_reg   <= LIMIT_W'(pwdata[TIMEOUT_W-1:0]) * LIMIT_W'(TICKS_PER_MS);
                end
                REG_TX_DELAY:   delay_reg  <= pwdata[DELAY_W-1:0];
                REG_ACTIVE_RX:  active_reg <= pwdata[ACTIVE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_BIT_PERIOD: prdata = DATA_W'(bit_period_reg);
            REG_TIMEOUT:    prdata = DATA_W'(timeout_reg);
            REG_TX_DELAY:   prdata = DATA_W'(delay_reg);
            REG_ACTIVE_RX:  prdata = DATA_W'(active_reg);
        endcase
    end

    // ---------------- exchange control ----------------
    assign accept   = in_valid && !in_stall;
    assign is_start = (req_type == REQ_START);
    assign start    = accept && is_start;
    assign tmo      = (elapsed_reg >= limit_reg);
    // end test uses the time before this tick advances it
    assign end_now  = accept && !is_start && busy_reg && (tmo || !(any_pending || tx_active));
    assign step     = accept && !is_start && busy_reg && !end_now;
    assign tick_now = elapsed_reg + 1'b1;

    always_comb
    begin
        busy_next    = busy_reg;
        elapsed_next = elapsed_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            elapsed_next = '0;
        end
        else if (end_now)
        begin
            busy_next = 1'b0;
        end
        else if (step)
        begin
            elapsed_next = tick_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // ---------------- receiver lanes ----------------
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        mcut_rx_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (start),
            .step      (step),
            .enable    (ACTIVE_W'(i) < active_reg),
            .line      (rx_lines[i]),
            .now       (tick_now),
            .period    (bit_period_reg),
            .pending   (lane_pend[i]),
            .stat_next (lane_stat[i])
        );
    end

    // ---------------- transmitter ----------------
    mcut_tx u_tx
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .step       (step),
        .send_byte  (send_byte),
        .delay      (delay_reg),
        .period     (bit_period_reg),
        .now        (tick_now),
        .active     (tx_active),
        .level_next (tx_level_next)
    );

    // ---------------- merge and output ----------------
    mcut_merge #(.NUM_LANES(NUM_LANES)) u_merge
    (
        .stat        (lane_stat),
        .pend        (lane_pend),
        .tx_level    (tx_level_next),
        .busy        (busy_next),
        .fin         (end_now),
        .tmo         (end_now && tmo),
        .any_pending (any_pending),
        .result      (result)
    );

    mcut_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (accept),
        .wdata     (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .rdata     (out_word),
        .full      (in_stall)
    );

    assign tx_line           = out_word.tx_line;
    assign busy_res          = out_word.busy;
    assign finished          = out_word.finished;
    assign timed_out         = out_word.timed_out;
    assign rx_done_mask      = out_word.done_mask;
    assign rx_connected_mask = out_word.conn_mask;
    assign rx_bytes          = out_word.bytes;

endmodule

// ===== src/mcut_checker.sv =====
// ----------------------------------------------------------------------------
// mcut_checker: port-level checks
// Consistency of the result word flags and of the output buffering.
// ----------------------------------------------------------------------------
module mcut_checker
    import mcut_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 busy_res,
    input logic                 finished,
    input logic                 timed_out,
    input logic [MAX_LINES-1:0] rx_done_mask,
    input logic [MAX_LINES-1:0] rx_connected_mask
);

    // the word that ends an exchange already shows it stopped
    a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> !busy_res)
        else $error("finished word still shows busy");

    a_tmo_is_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timed_out) |-> finished)
        else $error("timed_out without finished");

    a_done_conn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((rx_done_mask & ~rx_connected_mask) == '0))
        else $error("receiver done but not connected");

    // input stalls only while a word waits at the output
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(finished) && $stable(busy_res)))
        else $error("stalled word changed");

endmodule

bind multi_channel_uart_transfer_unit mcut_checker u_mcut_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .busy_res          (busy_res),
    .finished          (finished),
    .timed_out         (timed_out),
    .rx_done_mask      (rx_done_mask),
    .rx_connected_mask (rx_connected_mask)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: multi-channel UART transfer unit
// Sends start and tick words carrying framed receiver lines, programs the
// registers over APB between bursts, and checks each result word against a
// software model of the exchange. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
import mcut_pkg::*;

class exchange_scoreboard;
    logic [PERIOD_W-1:0]   period_cfg;
    logic [TIMEOUT_W-1:0]  timeout_cfg;
    logic [DELAY_W-1:0]    delay_cfg;
    logic [ACTIVE_W-1:0]   active_cfg;

    logic [31:0]           elapsed;
    logic                  busy;
    logic [1:0]            mode [MAX_LINES];
    logic [BYTE_W-1:0]     shift [MAX_LINES];
    int unsigned           taken [MAX_LINES];
    logic [31:0]           sample_due [MAX_LINES];
    int unsigned           pending;
    logic [FRAME_BITS-1:0] frame;
    int unsigned           sent;
    logic [31:0]           tx_due;
    logic                  tx_level;

    result_t               expected_q[$];
    int                    errors;

    function new();
        period_cfg  = RST_BIT_PERIOD;
        timeout_cfg = RST_TIMEOUT;
        delay_cfg   = '0;
        active_cfg  = '0;
        elapsed     = '0;
        busy        = 1'b0;
        pending     = 0;
        frame       = '1;
        sent        = FRAME_BITS;
        tx_due      = '0;
        tx_level    = 1'b1;
        errors      = 0;
        foreach (mode[i])
        begin
            mode[i]       = MODE_DISC;
            shift[i]      = '0;
            taken[i]      = 0;
            sample_due[i] = '0;
        end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            REG_BIT_PERIOD: period_cfg  = val[PERIOD_W-1:0];
            REG_TIMEOUT:    timeout_cfg = val[TIMEOUT_W-1:0];
            REG_TX_DELAY:   delay_cfg   = val[DELAY_W-1:0];
            REG_ACTIVE_RX:  active_cfg  = val[ACTIVE_W-1:0];
            default:        ;
        endcase
    endfunction

    // advance the exchange by one accepted word and queue the word it yields
    function void note_word(logic req, logic [BYTE_W-1:0] sbyte,
                            logic [MAX_LINES-1:0] lines);
        int unsigned armed;
        logic [31:0] period;
        logic [31:0] limit;
        logic        fin;
        logic        tmo;
        result_t     r;
        period = 32'(period_cfg);
        fin    = 1'b0;
        tmo    = 1'b0;
        if (req == REQ_START)
        begin
            armed = (active_cfg > MAX_LINES) ? MAX_LINES : active_cfg;
            pending = 0;
            for (int i = 0; i < MAX_LINES; i++)
            begin
                shift[i]      = '0;
                taken[i]      = 0;
                sample_due[i] = '0;
                if (i < armed && lines[i])
                begin
                    mode[i] = MODE_IDLE;
                    pending++;
                end
                else
                    mode[i] = MODE_DISC;
            end
            elapsed  = '0;
            frame    = {1'b1, sbyte, 1'b0};
            sent     = 0;
            tx_due   = 32'(delay_cfg);
            tx_level = 1'b1;
            busy     = 1'b1;
        end
        else if (busy)
        begin
            limit = 32'(timeout_cfg) * TICKS_PER_MS;
            // end test runs on the time before this tick
            if (elapsed >= limit || (pending == 0 && sent >= FRAME_BITS))
            begin
                busy = 1'b0;
                fin  = 1'b1;
                tmo  = (elapsed >= limit);
            end
            else
            begin
                elapsed++;
                for (int i = 0; i < MAX_LINES; i++)
                begin
                    if (mode[i] == MODE_IDLE && !lines[i])
                    begin
                        mode[i]       = MODE_RUN;
                        sample_due[i] = elapsed + period + period / 2;
                    end
                    else if (mode[i] == MODE_RUN && sample_due[i] <= elapsed)
                    begin
                        shift[i] = shift[i] | (BYTE_W'(lines[i]) << taken[i]);
                        taken[i]++;
                        sample_due[i] = sample_due[i] + period;
                        if (taken[i] >= DATA_BITS)
                        begin
                            mode[i] = MODE_DONE;
                            if (pending > 0)
                                pending--;
                        end
                    end
                end
                if (tx_due <= elapsed && sent < FRAME_BITS)
                begin
                    tx_level = frame[sent];
                    sent++;
                    tx_due = tx_due + period;
                end
            end
        end
        r.tx_line   = tx_level;
        r.busy      = busy;
        r.finished  = fin;
        r.timed_out = tmo;
        for (int i = 0; i < MAX_LINES; i++)
        begin
            r.done_mask[i]        = (mode[i] == MODE_DONE);
            r.conn_mask[i]        = (mode[i] != MODE_DISC);
            r.bytes[BYTE_W*i +: BYTE_W] = shift[i];
        end
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
            errors++;
        end
    endfunction

    function void check_word(result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: result word with nothing pending, expected none, got %h",
                     $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("tx_line", 32'(want.tx_line), 32'(got.tx_line));
        compare_field("busy_res", 32'(want.busy), 32'(got.busy));
        compare_field("finished", 32'(want.finished), 32'(got.finished));
        compare_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
        compare_field("rx_done_mask", 32'(want.done_mask), 32'(got.done_mask));
        compare_field("rx_connected_mask", 32'(want.conn_mask), 32'(got.conn_mask));
        compare_field("rx_bytes", want.bytes, got.bytes);
    endfunction
endclass

module testbench;

    localparam logic REQ_TICK = ~REQ_START;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_stall;
    logic                        req_type;
    logic [BYTE_W-1:0]           send_byte;
    logic [MAX_LINES-1:0]        rx_lines;
    logic                        out_valid;
    logic                        out_stall;
    logic                        tx_line;
    logic                        busy_res;
    logic                        finished;
    logic                        timed_out;
    logic [MAX_LINES-1:0]        rx_done_mask;
    logic [MAX_LINES-1:0]        rx_connected_mask;
    logic [MAX_LINES*BYTE_W-1:0] rx_bytes;

    exchange_scoreboard sb = new();

    int in_gap_max   = 4;
    int out_gap_max  = 4;
    int items_sent   = 0;
    int results_seen = 0;

    // receiver line waveforms: one 8N1 frame per line starting at wave_off
    int                wave_off  [MAX_LINES];
    logic [BYTE_W-1:0] wave_byte [MAX_LINES];
    int                wave_per   = 1;
    logic              wave_noise = 1'b0;

    multi_channel_uart_transfer_unit u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [MAX_LINES-1:0] lines_at(int k);
        logic [MAX_LINES-1:0] lv;
        int pos;
        for (int i = 0; i < MAX_LINES; i++)
        begin
            pos = (k - wave_off[i]) / wave_per;
            if (k < wave_off[i])
                lv[i] = 1'b1;
            else if (pos == 0)
                lv[i] = 1'b0;
            else if (pos <= DATA_BITS)
                lv[i] = wave_byte[i][pos-1];
            else
                lv[i] = 1'b1;
        end
        if (wave_noise)
            lv = lv ^ (4'($urandom) & 4'($urandom));
        return lv;
    endfunction

    task automatic send_word(logic req, logic [BYTE_W-1:0] sbyte,
                             logic [MAX_LINES-1:0] lines);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        send_byte <= sbyte;
        rx_lines  <= lines;
        do @(posedge clk); while (in_stall);
        sb.note_word(req, sbyte, lines);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic pick_config();
        int p;
        case ($urandom_range(0, 9))
            0:       p = 0;
            1, 2:    p = $urandom_range(6, 24);
            default: p = $urandom_range(1, 5);
        endcase
        write_reg(REG_BIT_PERIOD, p);
        write_reg(REG_TIMEOUT, ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 65535));
        write_reg(REG_TX_DELAY, ($urandom_range(0, 19) == 0) ?
                  $urandom_range(0, 1048575) : $urandom_range(0, 2 * p + 2));
        write_reg(REG_ACTIVE_RX, $urandom_range(0, 7));
    endtask

    // one start word, then ticks carrying framed lines; some exchanges are cut
    // short (next start lands while busy) or get registers rewritten midway
    task automatic run_exchange();
        int span;
        int ticks;
        int half;
        logic [MAX_LINES-1:0] first_lines;
        wave_per   = (sb.period_cfg == 0) ? 1 : int'(sb.period_cfg);
        wave_noise = ($urandom_range(0, 9) == 0);
        span = int'(sb.delay_cfg);
        foreach (wave_off[i])
        begin
            wave_off[i]  = $urandom_range(1, 3 * wave_per + 2);
            wave_byte[i] = $urandom_range(0, 255);
            if (wave_off[i] > span)
                span = wave_off[i];
        end
        span = span + 12 * wave_per + 3;
        if (span > 400)
            span = 400;
        ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span) : span;
        half  = ($urandom_range(0, 4) == 0) ? ticks / 2 : 0;
        first_lines = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : '1;
        send_word(REQ_START, 8'($urandom_range(0, 255)), first_lines);
        for (int k = 1; k <= ticks; k++)
        begin
            if (k == half)
            begin
                drain();
                write_reg(REG_BIT_PERIOD, $urandom_range(0, wave_per + 2));
                write_reg(REG_TIMEOUT, ($urandom_range(0, 3) == 0) ? 0 :
                          $urandom_range(1, 65535));
                write_reg(REG_TX_DELAY, $urandom_range(0, 20));
                write_reg(REG_ACTIVE_RX, $urandom_range(0, 7));
            end
            send_word(REQ_TICK, 8'($urandom_range(0, 255)), lines_at(k));
        end
    endtask

    // result side
    initial
    begin
        result_t got;
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, out_gap_max);
            // one long hold-off so the skid fills and in_stall rises
            if (results_seen == 150)
                hold = 80;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            got = {tx_line, busy_res, finished, timed_out,
                   rx_done_mask, rx_connected_mask, rx_bytes};
            sb.check_word(got);
            results_seen++;
        end
    end

    initial
    begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        int base;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        req_type  <= REQ_TICK;
        send_byte <= '0;
        rx_lines  <= '1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks before any start just echo the reset outputs
        send_word(REQ_TICK, 8'h00, 4'h0);
        send_word(REQ_TICK, 8'hFF, 4'hF);
        drain();

        // zero timeout with every other register at its top value
        write_reg(REG_TIMEOUT, 0);
        write_reg(REG_BIT_PERIOD, 32'hFFFF);
        write_reg(REG_TX_DELAY, 32'hF_FFFF);
        write_reg(REG_ACTIVE_RX, 7);
        send_word(REQ_START, 8'hFF, 4'hF);
        send_word(REQ_TICK, 8'h00, 4'hF);
        send_word(REQ_TICK, 8'hFF, 4'h0);
        send_word(REQ_START, 8'h00, 4'h0);
        send_word(REQ_TICK, 8'h00, 4'hF);
        drain();

        // zero bit period: sampling and transmit step on every tick
        write_reg(REG_BIT_PERIOD, 0);
        write_reg(REG_TIMEOUT, 32'hFFFF);
        write_reg(REG_TX_DELAY, 0);
        write_reg(REG_ACTIVE_RX, 4);
        wave_per   = 1;
        wave_noise = 1'b0;
        wave_off   = '{1, 2, 3, 4};
        wave_byte  = '{8'h00, 8'hFF, 8'h5A, 8'hC3};
        send_word(REQ_START, 8'hA5, 4'hF);
        for (int k = 1; k <= 16; k++)
            send_word(REQ_TICK, 8'h00, lines_at(k));

        // 1 ms timeout: first with a receiver that never sees a start bit,
        // then with the last stop bit landing on the timeout tick itself
        for (int v = 0; v < 2; v++)
        begin
            drain();
            write_reg(REG_BIT_PERIOD, 100);
            write_reg(REG_TIMEOUT, 1);
            write_reg(REG_TX_DELAY, (v == 0) ? 0 : 100);
            write_reg(REG_ACTIVE_RX, (v == 0) ? 1 : 0);
            send_word(REQ_START, 8'($urandom_range(0, 255)), '1);
            repeat (1003)
                send_word(REQ_TICK, 8'($urandom_range(0, 255)), '1);
        end

        base = items_sent;
        while (items_sent - base < 1800)
        begin
            drain();
            pick_config();
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 4;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
            repeat ($urandom_range(1, 3))
                run_exchange();
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mcut_pkg.sv
src/mcut_rx_lane.sv
src/mcut_tx.sv
src/mcut_merge.sv
src/mcut_out_buf.sv
src/multi_channel_uart_transfer_unit.sv
src/mcut_checker.sv
sim/testbench.sv
